>>> hdl/f32div_pkg.sv
// Shared types and constants for the float32 divider.
package f32div_pkg;

  localparam int WordWidth = 32;
  localparam int SigWidth = 24;
  localparam int QuoWidth = 31;
  localparam int ExpWidth = 11;

  localparam logic [31:0] QnanWord = 32'h7FC0_0000;
  localparam logic [31:0] ExpInf = 32'h7F80_0000;

  typedef struct packed {
    logic start;
    logic [SigWidth:0] sa;
    logic [SigWidth-1:0] sb;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QuoWidth-1:0] q;
  } div_rsp_t;

endpackage

>>> hdl/f32div_core.sv
// Restoring radix-2 significand divider, one quotient bit per cycle.
module f32div_core
  import f32div_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SigWidth+1:0] rem;
  logic [SigWidth+1:0] den;
  logic [QuoWidth-1:0] q;
  logic [4:0] count;
  logic busy;
  logic done;
  logic [SigWidth+1:0] diff;
  logic ge;

  assign ge = rem >= den;
  assign diff = rem - den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (count == '0);
      if (req.start) begin
        busy <= 1'b1;
        count <= 5'(QuoWidth - 1);
        rem <= {1'b0, req.sa};
        den <= {2'b00, req.sb};
        q <= '0;
      end else if (busy) begin
        q <= {q[QuoWidth-2:0], ge};
        rem <= (ge ? diff : rem) << 1;
        if (count == '0) begin
          busy <= 1'b0;
        end
        count <= count - 5'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q = q;

endmodule

>>> hdl/float32_divider_top.sv
// Top level of the IEEE binary32 divider.
// Usage: present dividend and divisor with valid; the block takes one
// transaction while ready is high and then drops ready until the quotient
// transaction has been taken on the output channel.
// The operands are unpacked and denormals normalized one bit per cycle by a
// shift sequencer, then a restoring divider produces 31 quotient bits, one a
// cycle, then the result is rounded and packed into the quotient register.
// Special cases (NaN, infinity, zero) bypass the divider and go straight to
// the output stage. The next input is taken in the cycle after the output
// handshake.
// The quotient register holds its value while ready on the output is low,
// and no new input is taken until it is delivered.
// Reset is synchronous and clears the sequencer, out_valid and the start strobe.
module float32_divider_top
  import f32div_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] quotient
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SNorm = 3'd1;
  localparam logic [2:0] SDiv = 3'd2;
  localparam logic [2:0] SWait = 3'd3;
  localparam logic [2:0] SOut = 3'd4;

  logic [2:0] state;
  logic [SigWidth-1:0] sa;
  logic [SigWidth-1:0] sb;
  logic signed [ExpWidth-1:0] ea;
  logic signed [ExpWidth-1:0] eb;
  logic sign;
  div_req_t req;
  div_rsp_t rsp;

  f32div_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  assign a_nan = (dividend[30:23] == 8'hFF) && (dividend[22:0] != '0);
  assign b_nan = (divisor[30:23] == 8'hFF) && (divisor[22:0] != '0);
  assign a_inf = (dividend[30:23] == 8'hFF) && (dividend[22:0] == '0);
  assign b_inf = (divisor[30:23] == 8'hFF) && (divisor[22:0] == '0);
  assign a_zero = dividend[30:0] == '0;
  assign b_zero = divisor[30:0] == '0;

  logic sgn_in;
  assign sgn_in = dividend[31] ^ divisor[31];

  // Rounding and packing of the quotient.
  logic [SigWidth:0] m0;
  logic [SigWidth-1:0] m;
  logic signed [ExpWidth-1:0] e0;
  logic signed [ExpWidth-1:0] e;
  logic [ExpWidth-1:0] sh;
  logic [SigWidth-1:0] den_sig;
  logic [31:0] packed_q;

  always_comb begin
    m0 = 25'((32'(rsp.q) + 32'h40) >> 7);
    e0 = ea - eb + ExpWidth'(126);
    if (m0[SigWidth]) begin
      m = m0[SigWidth:1];
      e = e0 + ExpWidth'(1);
    end else begin
      m = m0[SigWidth-1:0];
      e = e0;
    end
    sh = ExpWidth'(1) - e;
    den_sig = m >> sh[4:0];
    if (e >= ExpWidth'(255)) begin
      packed_q = {sign, 31'h7F80_0000};
    end else if (e <= 0) begin
      if (sh >= ExpWidth'(24)) begin
        packed_q = {sign, 31'd0};
      end else begin
        packed_q = {sign, 8'd0, den_sig[22:0]};
      end
    end else begin
      packed_q = {sign, e[7:0], m[22:0]};
    end
  end

  assign in_ready = state == SIdle;

  always_ff @(posedge clk) begin
    req.start <= !rst && (state == SNorm) && sa[SigWidth-1] && sb[SigWidth-1];
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
    end else begin
      case (state)
        SIdle: begin
          if (in_valid) begin
            sign <= sgn_in;
            if (a_nan) begin
              quotient <= dividend;
              state <= SOut;
            end else if (b_nan) begin
              quotient <= divisor;
              state <= SOut;
            end else if (a_inf) begin
              quotient <= b_inf ? QnanWord : {sgn_in, 31'h7F80_0000};
              state <= SOut;
            end else if (b_inf) begin
              quotient <= {sgn_in, 31'd0};
              state <= SOut;
            end else if (b_zero) begin
              quotient <= a_zero ? QnanWord : {sgn_in, 31'h7F80_0000};
              state <= SOut;
            end else if (a_zero) begin
              quotient <= {sgn_in, 31'd0};
              state <= SOut;
            end else begin
              sa <= {dividend[30:23] != '0, dividend[22:0]};
              sb <= {divisor[30:23] != '0, divisor[22:0]};
              ea <= (dividend[30:23] == '0) ? ExpWidth'(1)
                                            : ExpWidth'(dividend[30:23]);
              eb <= (divisor[30:23] == '0) ? ExpWidth'(1)
                                           : ExpWidth'(divisor[30:23]);
              state <= SNorm;
            end
          end
        end
        SNorm: begin
          if (!sa[SigWidth-1]) begin
            sa <= sa << 1;
            ea <= ea - ExpWidth'(1);
          end else if (!sb[SigWidth-1]) begin
            sb <= sb << 1;
            eb <= eb - ExpWidth'(1);
          end else begin
            // Keep the quotient in [1,2): double the dividend when it is below the divisor.
            req.sb <= sb;
            if (sb <= sa) begin
              req.sa <= {1'b0, sa};
              ea <= ea + ExpWidth'(1);
            end else begin
              req.sa <= {sa, 1'b0};
            end
            state <= SDiv;
          end
        end
        SDiv: begin
          state <= SWait;
        end
        SWait: begin
          if (rsp.done) begin
            quotient <= packed_q;
            state <= SOut;
          end
        end
        SOut: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= SIdle;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

>>> hdl/f32div_checker.sv
// Port-level assertions for the float32 divider, bound to the top level.
module f32div_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] quotient
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("Output transaction dropped or changed while stalled.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("Input taken while a quotient waits.");

  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Ready stayed high after an accepted transaction.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind float32_divider_top f32div_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .quotient(quotient)
);
